### src/prescaled_compare_timer_unit_macros.svh
// Assertion macros shared by the timer RTL.
`ifndef PRESCALED_COMPARE_TIMER_UNIT_MACROS_SVH
`define PRESCALED_COMPARE_TIMER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PCT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/pct_pkg.sv
// Types and constants for the prescaled compare timer.
`default_nettype none
package pct_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned DivW      = 12;
  localparam int unsigned FlagPortW = 4;
  localparam int unsigned IdxW      = 3;
  localparam int unsigned ActW      = 2;
  localparam int unsigned UserW     = ActW + IdxW;
  localparam int unsigned OutW      = 40;
  localparam int unsigned AddrW     = 3;

  typedef enum logic [ActW-1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef logic [IdxW-1:0] reg_idx_t;
  localparam reg_idx_t REG_STATUS = 3'd0;
  localparam reg_idx_t REG_IRQ_EN = 3'd1;
  localparam reg_idx_t REG_COUNT  = 3'd2;
  localparam reg_idx_t REG_CMP0   = 3'd3;

  // Configuration register indexes (paddr[2]).
  localparam logic CFG_DIVISOR = 1'b0;
  localparam logic CFG_ENABLE  = 1'b1;

endpackage
`default_nettype wire

### src/prescaled_compare_timer_unit.sv
// Prescaled 32-bit compare timer: item processing, result register and config port.
//
//  channel   direction  payload (low bit first)
//  s_*       in         tuser: action[1:0], reg_index[4:2]; tdata: write_data[31:0]
//  m_*       out        tdata: read_data[31:0], flag_bits[35:32], irq_out[36], zero[39:37]
//  apb       in/out     paddr[2] selects divisor (0x0) or enable (0x4)
//
// The state registers and the result register are both loaded at the accepting edge,
// so one beat a cycle is taken while the result is drained.
// The input stalls only while a result waits and m_tready is low.
// rst clears the counter, prescaler, compare values, flags, enables and configuration.
// Configuration writes take effect at the APB access edge.
`default_nettype none
module prescaled_compare_timer_unit #(
  parameter int unsigned NUM_COMPARE   = 3,
  parameter int unsigned PRESCALE_BITS = 12
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [pct_pkg::DataW-1:0]  s_tdata,   // write_data
  input  wire logic [pct_pkg::UserW-1:0]  s_tuser,   // action, reg_index
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic [pct_pkg::OutW-1:0]        m_tdata,   // read_data, flag_bits, irq_out
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [pct_pkg::AddrW-1:0]  paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import pct_pkg::*;

  localparam int unsigned FlagW = NUM_COMPARE + 1;

  logic [DivW-1:0]          divisor;
  logic                     timer_enable;
  logic [PRESCALE_BITS-1:0] prescale_count, prescale_count_next;
  logic [DataW-1:0]         count_value, count_value_next;
  logic [DataW-1:0]         compare_values [NUM_COMPARE];
  logic [FlagW-1:0]         status_flags, status_flags_next;
  logic [FlagW-1:0]         enable_mask, enable_mask_next;
  logic [DataW-1:0]         read_data;
  logic [FlagPortW-1:0]     flag_out;
  logic [15:0]              div_wide;
  logic [PRESCALE_BITS-1:0] div_eff;
  logic                     s_fire, is_tick, is_write, cfg_wr;
  action_t                  action;
  reg_idx_t                 reg_index;
  logic [DataW-1:0]         write_data;

  assign action     = action_t'(s_tuser[ActW-1:0]);
  assign reg_index  = s_tuser[UserW-1:ActW];
  assign write_data = s_tdata;

  assign s_tready = !m_tvalid || m_tready;
  assign s_fire   = s_tvalid && s_tready;
  assign is_tick  = s_fire && (action == ACT_TICK);
  assign is_write = s_fire && (action == ACT_WRITE);

  // Divisor is kept at 12 bits; only the low PRESCALE_BITS take part.
  assign div_wide = {{(16 - DivW){1'b0}}, divisor};
  assign div_eff  = div_wide[PRESCALE_BITS-1:0];

  always_comb begin
    prescale_count_next = prescale_count;
    count_value_next    = count_value;
    status_flags_next   = status_flags;
    enable_mask_next    = enable_mask;
    read_data           = '0;
    case (action)
      ACT_TICK: begin
        if (timer_enable) begin
          if (prescale_count >= div_eff) begin
            prescale_count_next = '0;
            count_value_next    = count_value + 32'd1;
            if (count_value == '1) begin
              status_flags_next[0] = 1'b1;
            end
            for (int ch = 0; ch < int'(NUM_COMPARE); ch++) begin
              if (count_value_next == compare_values[ch]) begin
                status_flags_next[ch+1] = 1'b1;
              end
            end
          end else begin
            prescale_count_next = prescale_count + PRESCALE_BITS'(1);
          end
        end
      end
      ACT_READ: begin
        if (reg_index == REG_STATUS) begin
          read_data[FlagW-1:0] = status_flags;
        end else if (reg_index == REG_IRQ_EN) begin
          read_data[FlagW-1:0] = enable_mask;
        end else if (reg_index == REG_COUNT) begin
          read_data = count_value;
        end
        for (int ch = 0; ch < int'(NUM_COMPARE); ch++) begin
          if (reg_index == IdxW'(int'(REG_CMP0) + ch)) begin
            read_data = compare_values[ch];
          end
        end
      end
      ACT_WRITE: begin
        if (reg_index == REG_STATUS) begin
          status_flags_next = status_flags & ~write_data[FlagW-1:0];
        end else if (reg_index == REG_IRQ_EN) begin
          enable_mask_next = write_data[FlagW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    flag_out            = '0;
    flag_out[FlagW-1:0] = status_flags_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count <= '0;
      count_value    <= '0;
      status_flags   <= '0;
      enable_mask    <= '0;
      for (int ch = 0; ch < int'(NUM_COMPARE); ch++) begin
        compare_values[ch] <= '0;
      end
    end else if (s_fire) begin
      prescale_count <= prescale_count_next;
      count_value    <= count_value_next;
      status_flags   <= status_flags_next;
      enable_mask    <= enable_mask_next;
      for (int ch = 0; ch < int'(NUM_COMPARE); ch++) begin
        if (is_write && reg_index == IdxW'(int'(REG_CMP0) + ch)) begin
          compare_values[ch] <= write_data;
        end
      end
    end
  end

  // Result register; it follows the state written at the same edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      m_tdata <= {3'b000, |(status_flags_next & enable_mask_next), flag_out, read_data};
    end
  end

  // APB configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      divisor      <= '0;
      timer_enable <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == CFG_DIVISOR) begin
        divisor <= pwdata[DivW-1:0];
      end else begin
        timer_enable <= pwdata[0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == CFG_ENABLE) begin
      prdata[0] = timer_enable;
    end else begin
      prdata[DivW-1:0] = divisor;
    end
  end

`include "prescaled_compare_timer_unit_macros.svh"

  `PCT_ASSERT_NEXT(a_disabled_tick_holds, is_tick && !timer_enable && !cfg_wr, $stable(count_value) && $stable(prescale_count), "disabled tick moved the timer")
  `PCT_ASSERT_NEXT(a_count_only_on_tick, !is_tick, $stable(count_value), "counter moved without a tick")
  `PCT_ASSERT_NOW(a_result_tracks_flags, m_tvalid, m_tdata[32 +: FlagW] == status_flags && m_tdata[36] == |(status_flags & enable_mask), "waiting result disagrees with flags")

endmodule
`default_nettype wire

### bench/tb_prescaled_compare_timer_unit.sv
// Self-checking testbench for the prescaled compare timer: stream beats, APB set-up, scoreboard.
`timescale 1ns / 1ps
module tb_prescaled_compare_timer_unit;
  import pct_pkg::*;

  localparam int unsigned RandomOps   = 1800;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned NumCmp      = 3;

  typedef struct packed {
    logic [31:0] read_data;
    logic [3:0]  flag_bits;
    logic        irq_out;
  } timer_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DataW-1:0]  s_tdata = '0;   // write_data[31:0]
  logic [UserW-1:0]  s_tuser = '0;   // action[1:0], reg_index[4:2]
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OutW-1:0]   m_tdata;        // read_data[31:0], flag_bits[35:32], irq_out[36], zero[39:37]
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  prescaled_compare_timer_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Timer state as the testbench expects it to be.
  logic [DivW-1:0]  mdl_divisor;
  logic             mdl_enable;
  logic [DivW-1:0]  mdl_prescale;
  logic [31:0]      mdl_count;
  logic [31:0]      mdl_compare [NumCmp];
  logic [3:0]       mdl_flags;
  logic [3:0]       mdl_irq_mask;

  timer_result_t    pending_results [$];
  timer_result_t    expected_beat;
  int unsigned      err_count = 0;
  int unsigned      cycles = 0;
  int unsigned      idle_pct = 14;
  int unsigned      rx_hold_until = 0;
  int unsigned      ops_sent = 0;

  initial begin
    mdl_divisor  = '0;
    mdl_enable   = 1'b0;
    mdl_prescale = '0;
    mdl_count    = '0;
    mdl_flags    = '0;
    mdl_irq_mask = '0;
    for (int i = 0; i < NumCmp; i++) mdl_compare[i] = '0;
  end

  function automatic timer_result_t timer_step(action_t act, reg_idx_t idx, logic [31:0] data);
    timer_result_t res;
    int unsigned   ch;
    res.read_data = '0;
    ch = int'(idx) - int'(REG_CMP0);
    case (act)
      ACT_TICK: begin
        if (mdl_enable) begin
          if (mdl_prescale >= mdl_divisor) begin
            mdl_prescale = '0;
            mdl_count    = mdl_count + 32'd1;
            if (mdl_count == 32'd0) mdl_flags[0] = 1'b1;
            for (int i = 0; i < NumCmp; i++)
              if (mdl_count == mdl_compare[i]) mdl_flags[i+1] = 1'b1;
          end else begin
            mdl_prescale = mdl_prescale + DivW'(1);
          end
        end
      end
      ACT_READ: begin
        if (idx == REG_STATUS)      res.read_data = {28'd0, mdl_flags};
        else if (idx == REG_IRQ_EN) res.read_data = {28'd0, mdl_irq_mask};
        else if (idx == REG_COUNT)  res.read_data = mdl_count;
        else if (idx >= REG_CMP0 && ch < NumCmp) res.read_data = mdl_compare[ch];
      end
      ACT_WRITE: begin
        // Status bits are write-one-to-clear; counter writes are dropped.
        if (idx == REG_STATUS)      mdl_flags = mdl_flags & ~data[3:0];
        else if (idx == REG_IRQ_EN) mdl_irq_mask = data[3:0];
        else if (idx >= REG_CMP0 && ch < NumCmp) mdl_compare[ch] = data;
      end
      default: ;
    endcase
    res.flag_bits = mdl_flags;
    res.irq_out   = |(mdl_flags & mdl_irq_mask);
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] want, logic [31:0] got);
    err_count++;
    if (err_count <= 30)
      $display("mismatch in %s at cycle %0d: expected 0x%0h, got 0x%0h", field, cycles, want, got);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (cycles < rx_hold_until) m_tready <= 1'b0;
    else                        m_tready <= ($urandom_range(0, 99) >= idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", 32'd0, m_tdata[31:0]);
      end else begin
        expected_beat = pending_results.pop_front();
        if (m_tdata[31:0] !== expected_beat.read_data)
          report_mismatch("read_data", expected_beat.read_data, m_tdata[31:0]);
        if (m_tdata[35:32] !== expected_beat.flag_bits)
          report_mismatch("flag_bits", {28'd0, expected_beat.flag_bits}, {28'd0, m_tdata[35:32]});
        if (m_tdata[36] !== expected_beat.irq_out)
          report_mismatch("irq_out", {31'd0, expected_beat.irq_out}, {31'd0, m_tdata[36]});
        if (m_tdata[39:37] !== 3'd0)
          report_mismatch("padding", 32'd0, {29'd0, m_tdata[39:37]});
      end
    end
  end

  // Called just after a rising edge; returns just after the accepting edge.
  task automatic send_timer_op(action_t act, reg_idx_t idx, logic [31:0] data);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {idx, act};
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    pending_results.push_back(timer_step(act, idx, data));
  endtask

  // Sampling on the falling edge keeps the check clear of the scoreboard's update.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
    @(posedge clk);
  endtask

  // The bus returns to idle after the access, so writes never overlap.
  task automatic cfg_write(logic sel, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == CFG_DIVISOR) mdl_divisor = value[DivW-1:0];
    else                    mdl_enable  = value[0];
    @(posedge clk);
  endtask

  task automatic test_register_access();
    send_timer_op(ACT_TICK, REG_STATUS, 32'd0);
    send_timer_op(ACT_NOP, reg_idx_t'(7), 32'hFFFF_FFFF);
    send_timer_op(ACT_WRITE, REG_COUNT, 32'hFFFF_FFFF);
    send_timer_op(ACT_WRITE, REG_CMP0, 32'hFFFF_FFFF);
    send_timer_op(ACT_WRITE, reg_idx_t'(REG_CMP0 + 1), 32'h0000_0000);
    send_timer_op(ACT_WRITE, reg_idx_t'(REG_CMP0 + 2), 32'hA5A5_5A5A);
    send_timer_op(ACT_WRITE, reg_idx_t'(6), 32'hDEAD_BEEF);
    send_timer_op(ACT_WRITE, reg_idx_t'(7), 32'h1234_5678);
    send_timer_op(ACT_WRITE, REG_IRQ_EN, 32'hFFFF_FFFF);
    for (int i = 0; i < 8; i++) send_timer_op(ACT_READ, reg_idx_t'(i), 32'd0);
    wait_idle();
  endtask

  task automatic test_compare_match();
    cfg_write(CFG_DIVISOR, 32'd0);
    cfg_write(CFG_ENABLE, 32'd1);
    send_timer_op(ACT_WRITE, REG_CMP0, mdl_count + 32'd2);
    send_timer_op(ACT_WRITE, reg_idx_t'(REG_CMP0 + 1), mdl_count + 32'd2);
    send_timer_op(ACT_WRITE, reg_idx_t'(REG_CMP0 + 2), mdl_count + 32'd4);
    send_timer_op(ACT_WRITE, REG_IRQ_EN, 32'h0000_0004);
    repeat (4) send_timer_op(ACT_TICK, REG_STATUS, 32'd0);
    send_timer_op(ACT_READ, REG_STATUS, 32'd0);
    send_timer_op(ACT_WRITE, REG_STATUS, 32'h0000_0002);
    send_timer_op(ACT_WRITE, REG_STATUS, 32'h0000_0004);
    send_timer_op(ACT_WRITE, REG_IRQ_EN, 32'h0000_000F);
    send_timer_op(ACT_WRITE, REG_STATUS, 32'hFFFF_FFFF);
    send_timer_op(ACT_READ, REG_COUNT, 32'd0);
    wait_idle();
  endtask

  // Largest divisor, then a lowered divisor below the running prescale count,
  // then ticks with the timer switched off.
  task automatic test_prescale_edges();
    cfg_write(CFG_DIVISOR, 32'd4095);
    repeat (12) send_timer_op(ACT_TICK, REG_STATUS, 32'd0);
    send_timer_op(ACT_READ, REG_COUNT, 32'd0);
    wait_idle();
    cfg_write(CFG_DIVISOR, 32'd3);
    repeat (3) send_timer_op(ACT_TICK, REG_STATUS, 32'd0);
    send_timer_op(ACT_READ, REG_COUNT, 32'd0);
    wait_idle();
    cfg_write(CFG_ENABLE, 32'd0);
    repeat (3) send_timer_op(ACT_TICK, REG_STATUS, 32'd0);
    send_timer_op(ACT_READ, REG_COUNT, 32'd0);
    wait_idle();
  endtask

  task automatic random_timer_op();
    int unsigned pick;
    int unsigned ch;
    logic [31:0] data;
    pick = $urandom_range(0, 99);
    ch   = $urandom_range(0, NumCmp - 1);
    data = $urandom();
    if (pick < 55) begin
      send_timer_op(ACT_TICK, reg_idx_t'($urandom_range(0, 7)), data);
    end else if (pick < 70) begin
      send_timer_op(ACT_READ, reg_idx_t'($urandom_range(0, 7)), data);
    end else if (pick < 80) begin
      // Compare values land just ahead of the count so that matches happen.
      if ($urandom_range(0, 3) != 0) data = mdl_count + $urandom_range(1, 20);
      send_timer_op(ACT_WRITE, reg_idx_t'(REG_CMP0 + ch), data);
    end else if (pick < 87) begin
      if ($urandom_range(0, 1) == 0) data = 32'd1 << $urandom_range(0, 3);
      send_timer_op(ACT_WRITE, REG_STATUS, data);
    end else if (pick < 93) begin
      send_timer_op(ACT_WRITE, REG_IRQ_EN, data);
    end else if (pick < 96) begin
      send_timer_op(ACT_WRITE, reg_idx_t'($urandom_range(0, 1) ? REG_COUNT : $urandom_range(6, 7)),
                    data);
    end else begin
      send_timer_op(ACT_NOP, reg_idx_t'($urandom_range(0, 7)), data);
    end
    ops_sent++;
  endtask

  task automatic test_random_traffic();
    int unsigned phase_no;
    int unsigned burst;
    int unsigned div_pick;
    phase_no = 0;
    while (ops_sent < RandomOps) begin
      wait_idle();
      div_pick = $urandom_range(0, 9);
      if (phase_no == 0)      cfg_write(CFG_DIVISOR, 32'd0);
      else if (phase_no == 2) cfg_write(CFG_DIVISOR, 32'd4095);
      else if (div_pick < 6)  cfg_write(CFG_DIVISOR, $urandom_range(0, 3));
      else if (div_pick < 9)  cfg_write(CFG_DIVISOR, $urandom_range(0, 15));
      else                    cfg_write(CFG_DIVISOR, $urandom_range(0, 4095));
      cfg_write(CFG_ENABLE, ($urandom_range(0, 9) != 0) ? 32'd1 : 32'd0);
      // One long stretch with no idling on either side.
      idle_pct = (phase_no == 1) ? 0 : 14;
      burst    = (phase_no == 1) ? 300 : $urandom_range(20, 120);
      repeat (burst) random_timer_op();
      phase_no++;
    end
    idle_pct = 14;
    wait_idle();
  endtask

  // The receiver stops for a long stretch while beats keep coming, so the input stalls.
  task automatic test_output_backpressure();
    cfg_write(CFG_DIVISOR, 32'd1);
    cfg_write(CFG_ENABLE, 32'd1);
    rx_hold_until = cycles + 300;
    repeat (40) random_timer_op();
    wait_idle();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_access();
    test_compare_match();
    test_prescale_edges();
    test_output_backpressure();
    test_random_traffic();
    repeat (DrainCycles) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/pct_pkg.sv
src/prescaled_compare_timer_unit.sv
bench/tb_prescaled_compare_timer_unit.sv
